[rtl/rgbgs_pkg.sv]
// shared types, constants and register codes of the rgb 3x3 window filter
`timescale 1ns / 1ps

package rgbgs_pkg;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 4096;

  localparam int NUM_LANES = 3;
  localparam int NUM_TAPS  = 9;

  // filter modes
  localparam logic [1:0] MODE_GAUSS = 2'd0;
  localparam logic [1:0] MODE_HORIZ = 2'd1;
  localparam logic [1:0] MODE_VERT  = 2'd2;
  localparam logic [1:0] MODE_MAG   = 2'd3;

  // register indexes on the configuration port
  localparam logic [1:0] REG_MODE   = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  localparam logic [10:0] RST_WIDTH  = 11'd1024;
  localparam logic [12:0] RST_HEIGHT = 13'd1024;

  // per result control handed to every lane
  typedef struct packed {
    logic [1:0] mode;
    logic       top_off;
    logic       bot_off;
    logic       left_off;
    logic       right_off;
  } rgbgs_ctrl_t;

endpackage

[rtl/rgbgs_ram.sv]
// generic single write port ram with registered read
`timescale 1ns / 1ps

module rgbgs_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/rgbgs_lane.sv]
// one colour channel: gaussian or sobel sums, then an iterative square root
`timescale 1ns / 1ps

module rgbgs_lane
  import rgbgs_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [NUM_TAPS-1:0][7:0]  taps,
  input  rgbgs_ctrl_t               ctrl,
  output logic                      done,
  output logic [7:0]                res
);

  typedef enum logic [3:0] {
    L_IDLE = 4'b0001,
    L_SQR  = 4'b0010,
    L_ROOT = 4'b0100,
    L_DONE = 4'b1000
  } lane_state_t;

  lane_state_t state;

  logic [11:0] t [NUM_TAPS];
  logic [11:0] gsum;
  logic signed [11:0] sh_raw, sv_raw;
  logic [7:0]  sh_cl, sv_cl;

  logic [7:0]  gauss_q, sh_q, sv_q;
  logic [1:0]  mode_q;
  logic        border_q;
  logic [16:0] sq;
  logic [16:0] rem;
  logic [16:0] root;
  logic [16:0] bitv;
  logic [17:0] trial;

  // gaussian taps with zero padding outside the frame
  always_comb begin
    for (int k = 0; k < NUM_TAPS; k++) begin
      t[k] = {4'd0, taps[k]};
      if ((k % 3 == 0) && ctrl.top_off) t[k] = '0;
      if ((k % 3 == 2) && ctrl.bot_off) t[k] = '0;
      if ((k / 3 == 0) && ctrl.left_off) t[k] = '0;
      if ((k / 3 == 2) && ctrl.right_off) t[k] = '0;
    end
    gsum = t[0] + (t[3] << 1) + t[6]
         + ((t[1] + (t[4] << 1) + t[7]) << 1)
         + t[2] + (t[5] << 1) + t[8];
    // top row minus bottom row, right column minus left column
    sh_raw = $signed({4'd0, taps[0]}) + $signed({3'd0, taps[3], 1'b0}) + $signed({4'd0, taps[6]})
           - $signed({4'd0, taps[2]}) - $signed({3'd0, taps[5], 1'b0}) - $signed({4'd0, taps[8]});
    sv_raw = $signed({4'd0, taps[6]}) + $signed({3'd0, taps[7], 1'b0}) + $signed({4'd0, taps[8]})
           - $signed({4'd0, taps[0]}) - $signed({3'd0, taps[1], 1'b0}) - $signed({4'd0, taps[2]});
    sh_cl = sh_raw < 0 ? 8'd0 : (sh_raw > 12'sd255 ? 8'd255 : sh_raw[7:0]);
    sv_cl = sv_raw < 0 ? 8'd0 : (sv_raw > 12'sd255 ? 8'd255 : sv_raw[7:0]);
  end

  assign sq    = 17'({8'd0, sh_q} * {8'd0, sh_q}) + 17'({8'd0, sv_q} * {8'd0, sv_q});
  assign trial = {1'b0, root} + {1'b0, bitv};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= L_IDLE;
    end else begin
      unique case (state)
        L_IDLE: begin
          if (start) state <= L_SQR;
        end
        L_SQR:  state <= L_ROOT;
        L_ROOT: begin
          if (bitv == 17'd1) state <= L_DONE;
        end
        L_DONE: state <= L_IDLE;
        default: state <= L_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == L_IDLE && start) begin
      gauss_q  <= gsum[11:4];
      sh_q     <= sh_cl;
      sv_q     <= sv_cl;
      mode_q   <= ctrl.mode;
      border_q <= ctrl.top_off | ctrl.bot_off | ctrl.left_off | ctrl.right_off;
    end
    if (state == L_SQR) begin
      rem  <= sq;
      root <= '0;
      bitv <= 17'h10000;
    end
    if (state == L_ROOT) begin
      if ({1'b0, rem} >= trial) begin
        rem  <= rem - trial[16:0];
        root <= (root >> 1) + bitv;
      end else begin
        root <= root >> 1;
      end
      bitv <= bitv >> 2;
    end
  end

  assign done = (state == L_DONE);

  always_comb begin
    unique case (mode_q)
      MODE_GAUSS: res = gauss_q;
      MODE_HORIZ: res = border_q ? 8'd0 : sh_q;
      MODE_VERT:  res = border_q ? 8'd0 : sv_q;
      MODE_MAG:   res = border_q ? 8'd0 : (root > 17'd255 ? 8'd255 : root[7:0]);
      default:    res = gauss_q;
    endcase
  end

endmodule

[rtl/rgb_3x3_gauss_sobel_filter.sv]
// top level: line stores, window, three channel lanes and the result merge
// pixel flow: a new pixel is taken only once the results of the last one have
//   transferred; a pixel in the last column of a row gives a second result after
//   the first one transfers; each result waits on the 9-step square root in each
//   lane
// reset: synchronous; a clearing pass over all MAX_WIDTH addresses zeroes both line stores
`timescale 1ns / 1ps

module rgb_3x3_gauss_sobel_filter
  import rgbgs_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic        clk,
  input  logic        rst,
  // apb configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // pixel channel
  input  logic        pix_valid,
  output logic        pix_ready,
  input  logic        cmd,
  input  logic [7:0]  chan_blue,
  input  logic [7:0]  chan_green,
  input  logic [7:0]  chan_red,
  // result channel
  output logic        res_valid,
  input  logic        res_ready,
  output logic [7:0]  res_blue,
  output logic [7:0]  res_green,
  output logic [7:0]  res_red,
  output logic        run_last,
  output logic        row_end,
  output logic        frame_end
);

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;  // column index
  localparam int EW = $clog2(MAX_WIDTH + 1);                     // effective width
  localparam int RW = $clog2(MAX_HEIGHT + 1);                    // row count and height

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_READ  = 6'b000100,
    S_CALC  = 6'b001000,
    S_WAIT  = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  state_t state;

  // configuration registers
  logic [1:0]  filter_mode;
  logic [10:0] frame_width;
  logic [12:0] frame_height;
  logic        cfg_wr;

  // frame position
  logic [RW-1:0] row_count;
  logic [CW-1:0] col_count;
  logic [CW-1:0] clr_cnt;

  // latched item
  logic [RW-1:0] r_q;
  logic [CW-1:0] c_q;
  logic [23:0]   px_q;

  // window, index col*3+row, col 0 leftmost, row 0 top
  logic [23:0] win [NUM_TAPS];

  // position of the result under way
  logic [RW-1:0] er_q;
  logic [CW-1:0] ec_q;
  logic          pend2;
  rgbgs_ctrl_t   ctrl;

  // effective sizes and normalised counters
  logic [31:0]   fw32, fh32;
  logic [EW-1:0] eff_w;
  logic [RW-1:0] eff_h;
  logic [CW-1:0] c_norm;
  logic [RW-1:0] r_norm;
  logic [CW-1:0] c_inc;
  logic          c_wrap;
  logic [RW-1:0] r_inc;

  // line stores
  logic          ram_we;
  logic [CW-1:0] ram_waddr;
  logic [23:0]   a_wdata, b_wdata, a_rdata, b_rdata;

  // lanes
  logic [NUM_LANES-1:0] lane_done;
  logic [7:0]           lane_res [NUM_LANES];
  logic                 lane_start;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_comb begin
    unique case (paddr[3:2])
      REG_MODE:   prdata = {30'd0, filter_mode};
      REG_WIDTH:  prdata = {21'd0, frame_width};
      REG_HEIGHT: prdata = {19'd0, frame_height};
      default:    prdata = '0;
    endcase
  end

  // sizes clamped to 3..max
  always_comb begin
    fw32 = 32'(frame_width);
    fh32 = 32'(frame_height);
    if (fw32 < 32'd3) fw32 = 32'd3;
    if (fw32 > 32'(MAX_WIDTH)) fw32 = 32'(MAX_WIDTH);
    if (fh32 < 32'd3) fh32 = 32'd3;
    if (fh32 > 32'(MAX_HEIGHT)) fh32 = 32'(MAX_HEIGHT);
    eff_w = EW'(fw32);
    eff_h = RW'(fh32);
  end

  assign c_norm = (EW'(col_count) >= eff_w) ? '0 : col_count;
  assign r_norm = (row_count > eff_h) ? '0 : row_count;

  // counter step after the item
  always_comb begin
    c_wrap = (EW'(c_q) + EW'(1)) >= eff_w;
    c_inc  = c_wrap ? '0 : c_q + CW'(1);
    r_inc  = r_q;
    if (c_wrap) begin
      r_inc = r_q + RW'(1);
      if (r_inc > eff_h) r_inc = '0;
    end
  end

  assign pix_ready  = (state == S_IDLE);
  assign lane_start = (state == S_CALC);

  // line store write: zero during the clearing pass, else the shift of rows
  assign ram_we    = (state == S_CLEAR) || (state == S_READ);
  assign ram_waddr = (state == S_CLEAR) ? clr_cnt : c_q;
  assign a_wdata   = (state == S_CLEAR) ? 24'd0 : px_q;
  assign b_wdata   = (state == S_CLEAR) ? 24'd0 : a_rdata;

  rgbgs_ram #(.WIDTH(24), .DEPTH(MAX_WIDTH)) u_line_a (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (a_wdata),
    .raddr (c_norm),
    .rdata (a_rdata)
  );

  rgbgs_ram #(.WIDTH(24), .DEPTH(MAX_WIDTH)) u_line_b (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (b_wdata),
    .raddr (c_norm),
    .rdata (b_rdata)
  );

  // control of the lanes from the result position
  always_comb begin
    ctrl.mode      = filter_mode;
    ctrl.top_off   = (er_q == '0);
    ctrl.bot_off   = (er_q + RW'(1)) >= eff_h;
    ctrl.left_off  = (ec_q == '0);
    ctrl.right_off = (EW'(ec_q) + EW'(1)) >= eff_w;
  end

  // one lane per colour channel
  for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
    logic [NUM_TAPS-1:0][7:0] taps;
    for (genvar k = 0; k < NUM_TAPS; k++) begin : g_tap
      assign taps[k] = win[k][8*l +: 8];
    end
    rgbgs_lane u_lane (
      .clk   (clk),
      .rst   (rst),
      .start (lane_start),
      .taps  (taps),
      .ctrl  (ctrl),
      .done  (lane_done[l]),
      .res   (lane_res[l])
    );
  end

  // sequencer, counters and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr_cnt      <= '0;
      filter_mode  <= MODE_GAUSS;
      frame_width  <= RST_WIDTH;
      frame_height <= RST_HEIGHT;
      row_count    <= '0;
      col_count    <= '0;
      pend2        <= 1'b0;
      res_valid    <= 1'b0;
      for (int k = 0; k < NUM_TAPS; k++) win[k] <= '0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + CW'(1);
          if (clr_cnt == CW'(MAX_WIDTH - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (pix_valid) state <= S_READ;
        end
        S_READ: begin
          // window takes the column: older rows on top, the new pixel below
          for (int k = 0; k < 6; k++) win[k] <= win[k+3];
          win[6]    <= b_rdata;
          win[7]    <= a_rdata;
          win[8]    <= px_q;
          row_count <= r_inc;
          col_count <= c_inc;
          er_q      <= r_q - RW'(1);
          ec_q      <= c_q - CW'(1);
          pend2     <= (r_q != '0) && (EW'(c_q) == eff_w - EW'(1));
          if (r_q != '0 && c_q != '0) state <= S_CALC;
          else state <= S_IDLE;
        end
        S_CALC: state <= S_WAIT;
        S_WAIT: begin
          if (lane_done[0]) begin
            res_valid <= 1'b1;
            state     <= S_OUT;
          end
        end
        S_OUT: begin
          if (res_ready) begin
            res_valid <= 1'b0;
            if (pend2) begin
              // last column of the row: shift in an empty column
              for (int k = 0; k < 6; k++) win[k] <= win[k+3];
              win[6] <= '0;
              win[7] <= '0;
              win[8] <= '0;
              ec_q   <= CW'(eff_w - EW'(1));
              pend2  <= 1'b0;
              state  <= S_CALC;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
      if (cfg_wr) begin
        unique case (paddr[3:2])
          REG_MODE:   filter_mode <= pwdata[1:0];
          REG_WIDTH: begin
            frame_width <= pwdata[10:0];
            row_count   <= '0;
            col_count   <= '0;
          end
          REG_HEIGHT: begin
            frame_height <= pwdata[12:0];
            row_count    <= '0;
            col_count    <= '0;
          end
          default: ;
        endcase
      end
    end
  end

  // pixel latch on transfer; a flush pixel or one in the padding row is zero
  always_ff @(posedge clk) begin
    if (pix_valid && pix_ready) begin
      r_q  <= r_norm;
      c_q  <= c_norm;
      px_q <= (cmd || r_norm >= eff_h) ? 24'd0 : {chan_red, chan_green, chan_blue};
    end
  end

  // merge the lanes into the result register
  always_ff @(posedge clk) begin
    if (state == S_WAIT && lane_done[0]) begin
      res_blue  <= lane_res[0];
      res_green <= lane_res[1];
      res_red   <= lane_res[2];
      run_last  <= ~pend2;
      row_end   <= (EW'(ec_q) == eff_w - EW'(1));
      frame_end <= (EW'(ec_q) == eff_w - EW'(1)) && (er_q == eff_h - RW'(1));
    end
  end

`ifndef SYNTHESIS
  a_lanes_together: assert property (@(posedge clk) disable iff (rst)
    lane_done[0] == lane_done[1] && lane_done[1] == lane_done[2])
    else $error("lanes finished out of step");

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    pix_ready |-> state == S_IDLE && !res_valid)
    else $error("pixel taken while a result is under way");

  a_accept_read: assert property (@(posedge clk) disable iff (rst)
    pix_valid && pix_ready |=> state == S_READ)
    else $error("accepted pixel not followed by a line store read");

  a_second_not_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && pend2 |-> !run_last)
    else $error("first of two results marked as last");

  a_valid_out_state: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> state == S_OUT)
    else $error("result valid outside the output state");
`endif

endmodule
